@@ design/apm_pkg.sv @@
// Shared types, constants and the reciprocal table of the audio level meter.
package apm_pkg;

  localparam int MaxFramesDef = 4096;
  localparam int MaxChanDef   = 8;
  localparam int NumChanPorts = 8;

  localparam int SampleW  = 24;
  localparam int LevelW   = 24;
  localparam int CountW   = 4;
  localparam int HoldW    = 16;
  localparam int SumSqW   = 64;
  localparam int SquareW  = 2 * LevelW;
  localparam int MixW     = SampleW + 3;
  localparam int RecipW   = 32;
  localparam int RecipSh  = 31;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  localparam logic [LevelW-1:0] FullScale = 24'd4194304;
  localparam logic [LevelW-1:0] LevelMax  = 24'd8388608;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS    = 1'b1;

  // Operation and result kind codes
  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_LEVEL,
    ST_REPORT,
    ST_TICK
  } mtr_state_e;

  typedef enum logic [1:0] {
    LV_IDLE,
    LV_DIV,
    LV_SQRT
  } lvl_state_e;

  // ceil(2^31 / n): exact floor division for dividends below 2^27
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd1073741824;
      4'd3:    r = 32'd715827883;
      4'd4:    r = 32'd536870912;
      4'd5:    r = 32'd429496730;
      4'd6:    r = 32'd357913942;
      4'd7:    r = 32'd306783379;
      4'd8:    r = 32'd268435456;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

@@ design/apm_lane.sv @@
// One channel lane: gate a sample by the active channel count and register it.
module apm_lane
  import apm_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  logic    active_i,
  input  sample_t sample_i,
  output sample_t lane_o
);

  sample_t lane_q;
  sample_t lane_d;

  assign lane_d = active_i ? sample_i : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ design/apm_merge.sv @@
// Merge stage: sum the lanes, divide by the channel count and square the mono magnitude.
module apm_merge
  import apm_pkg::*;
#(
  parameter int NUM_LANES = MaxChanDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CountW-1:0]   ch_i,
  input  sample_t             lane_i [NUM_LANES],
  output logic                valid_o,
  output logic [LevelW-1:0]   mag_o,
  output logic [SquareW-1:0]  sq_o
);

  localparam int ProdW = MixW + RecipW;

  logic signed [MixW-1:0] sum_s;
  logic [MixW-1:0]        absum_d;
  logic [ProdW-1:0]       prod;

  logic                   v1_q, v2_q, v3_q;
  logic [MixW-1:0]        absum_q;
  logic [RecipW-1:0]      recip_q;
  logic [LevelW-1:0]      mag_q;
  logic [LevelW-1:0]      mag3_q;
  logic [SquareW-1:0]     sq_q;

  always_comb begin
    sum_s = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_s = sum_s + MixW'(lane_i[i]);
    end
  end

  // Truncation toward zero: divide the magnitude, the sign drops out
  assign absum_d = sum_s[MixW-1] ? MixW'(-sum_s) : MixW'(sum_s);
  assign prod    = ProdW'(absum_q) * ProdW'(recip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      absum_q <= absum_d;
      recip_q <= recip(ch_i);
    end
    if (v1_q) begin
      mag_q <= prod[RecipSh +: LevelW];
    end
    if (v2_q) begin
      mag3_q <= mag_q;
      sq_q   <= SquareW'(mag_q) * SquareW'(mag_q);
    end
  end

  assign valid_o = v3_q;
  assign mag_o   = mag3_q;
  assign sq_o    = sq_q;

endmodule

@@ design/apm_lvl.sv @@
// Buffer level unit: restoring divide of the square sum, then a bit-pair square root.
module apm_lvl
  import apm_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [SumSqW-1:0]                    sum_i,
  input  logic [$clog2(MAX_FRAMES + 1)-1:0]    frames_i,
  output logic                                 done_o,
  output logic [LevelW-1:0]                    rms_o
);

  localparam int FrameW    = $clog2(MAX_FRAMES + 1);
  localparam int DivSteps  = SumSqW;
  localparam int RootW     = SumSqW / 2;
  localparam int SremW     = RootW + 2;
  localparam int StepW     = $clog2(DivSteps);

  lvl_state_e          state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                done_q, done_d;
  logic [SumSqW-1:0]   quo_q, quo_d;
  logic [FrameW-1:0]   drem_q, drem_d;
  logic [FrameW-1:0]   dvsr_q, dvsr_d;
  logic [SremW-1:0]    srem_q, srem_d;
  logic [RootW-1:0]    root_q, root_d;

  logic [FrameW:0]     dsh;
  logic [FrameW:0]     ddiff;
  logic                dge;
  logic [SremW+1:0]    srt;
  logic [SremW+1:0]    trial;
  logic [SremW+1:0]    sdiff;
  logic                sge;

  assign dsh   = {drem_q, quo_q[SumSqW-1]};
  assign dge   = dsh >= {1'b0, dvsr_q};
  assign ddiff = dsh - {1'b0, dvsr_q};

  assign srt   = {srem_q, quo_q[SumSqW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign sge   = srt >= trial;
  assign sdiff = srt - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LV_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    drem_q <= drem_d;
    dvsr_q <= dvsr_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    drem_d  = drem_q;
    dvsr_d  = dvsr_q;
    srem_d  = srem_q;
    root_d  = root_q;
    case (state_q)
      LV_IDLE: begin
        if (start_i) begin
          quo_d   = sum_i;
          dvsr_d  = frames_i;
          drem_d  = '0;
          step_d  = '0;
          state_d = LV_DIV;
        end
      end
      LV_DIV: begin
        // One quotient bit per cycle
        quo_d  = {quo_q[SumSqW-2:0], dge};
        drem_d = dge ? ddiff[FrameW-1:0] : dsh[FrameW-1:0];
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = LV_SQRT;
        end
      end
      LV_SQRT: begin
        // Consume two radicand bits per cycle, one root bit out
        quo_d  = {quo_q[SumSqW-3:0], 2'b00};
        srem_d = sge ? sdiff[SremW-1:0] : srt[SremW-1:0];
        root_d = {root_q[RootW-2:0], sge};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(RootW - 1)) begin
          step_d  = '0;
          done_d  = 1'b1;
          state_d = LV_IDLE;
        end
      end
      default: begin
        state_d = LV_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign rms_o  = (root_q > RootW'(LevelMax)) ? LevelMax : root_q[LevelW-1:0];

endmodule

@@ design/audio_peak_rms_meter.sv @@
// Top level of the audio peak and RMS level meter.
//
// The meter takes one transaction at a time. A frame transaction carries up
// to eight signed Q2.22 samples; one lane per channel gates and registers its
// sample, and the merge stage sums the lanes, divides by the channel count
// through a reciprocal multiply and squares the mono magnitude, three
// registered steps. A frame that is not the last of its buffer holds off
// the next frame until its merge result has been added to the accumulators.
// The frame marked last also runs the level unit, which divides the square
// sum by the frame count one quotient bit per cycle and then takes the
// square root one root bit per cycle; the level report is then written into
// the output register once the previous result has been taken. A tick
// transaction also waits until the output register is free. Peak and RMS
// come out in Q2.22 and saturate at 2.0; the clip indication is held for
// hold_ticks millisecond ticks after a buffer whose peak reached 1.0, and a
// hold of zero turns it off. Configuration writes are always taken, but
// belong only to a quiet block.
module audio_peak_rms_meter
  import apm_pkg::*;
#(
  parameter int MAX_FRAMES   = MaxFramesDef,
  parameter int MAX_CHANNELS = MaxChanDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  sample_t              chan0_i,
  input  sample_t              chan1_i,
  input  sample_t              chan2_i,
  input  sample_t              chan3_i,
  input  sample_t              chan4_i,
  input  sample_t              chan5_i,
  input  sample_t              chan6_i,
  input  sample_t              chan7_i,
  input  logic                 last_frame_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic [LevelW-1:0]    peak_level_o,
  output logic [LevelW-1:0]    rms_level_o,
  output logic                 clipped_recently_o
);

  localparam int FrameW = $clog2(MAX_FRAMES + 1);

  // Configuration registers
  logic [CountW-1:0]  chan_cnt_q;
  logic [HoldW-1:0]   hold_q;

  // Sequencer and accumulators
  mtr_state_e         state_q, state_d;
  logic               start_q, start_d;
  logic               last_q;
  logic [LevelW-1:0]  run_peak_q, run_peak_d;
  logic [SumSqW-1:0]  sum_sq_q, sum_sq_d;
  logic [FrameW-1:0]  frames_q, frames_d;
  logic [LevelW-1:0]  held_peak_q, held_peak_d;
  logic [LevelW-1:0]  held_rms_q, held_rms_d;
  logic [HoldW-1:0]   clip_cnt_q, clip_cnt_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               out_kind_q, out_kind_d;
  logic [LevelW-1:0]  out_peak_q, out_peak_d;
  logic [LevelW-1:0]  out_rms_q, out_rms_d;
  logic               out_clip_q, out_clip_d;

  logic               in_accept;
  logic               out_free;
  logic [CountW-1:0]  ch_eff;
  sample_t            chan_in [NumChanPorts];
  sample_t            lane_val [MAX_CHANNELS];

  logic               mrg_valid;
  logic [LevelW-1:0]  mrg_mag;
  logic [SquareW-1:0] mrg_sq;

  logic [LevelW-1:0]  peak_nxt;
  logic [SumSqW:0]    sum_wide;
  logic [SumSqW-1:0]  sum_nxt;
  logic [FrameW-1:0]  frames_nxt;
  logic [HoldW-1:0]   clip_arm;
  logic [HoldW-1:0]   clip_dec;

  logic               lvl_start;
  logic               lvl_done;
  logic [LevelW-1:0]  lvl_rms;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= CountW'(2);
      hold_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data_i[CountW-1:0];
        REG_HOLD_TICKS:    hold_q     <= cfg_data_i[HoldW-1:0];
        default:           hold_q     <= hold_q;
      endcase
    end
  end

  // Clamp the channel count to one through MAX_CHANNELS
  assign ch_eff = (chan_cnt_q == '0) ? CountW'(1) :
                  (chan_cnt_q > CountW'(MAX_CHANNELS)) ? CountW'(MAX_CHANNELS) :
                  chan_cnt_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign chan_in[0] = chan0_i;
  assign chan_in[1] = chan1_i;
  assign chan_in[2] = chan2_i;
  assign chan_in[3] = chan3_i;
  assign chan_in[4] = chan4_i;
  assign chan_in[5] = chan5_i;
  assign chan_in[6] = chan6_i;
  assign chan_in[7] = chan7_i;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    apm_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (in_accept),
      .active_i (CountW'(c) < ch_eff),
      .sample_i (chan_in[c]),
      .lane_o   (lane_val[c])
    );
  end

  apm_merge #(
    .NUM_LANES (MAX_CHANNELS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .ch_i    (ch_eff),
    .lane_i  (lane_val),
    .valid_o (mrg_valid),
    .mag_o   (mrg_mag),
    .sq_o    (mrg_sq)
  );

  // Accumulator updates for the frame leaving the merge stage
  assign peak_nxt   = (mrg_mag > run_peak_q) ? mrg_mag : run_peak_q;
  assign sum_wide   = {1'b0, sum_sq_q} + (SumSqW + 1)'(mrg_sq);
  assign sum_nxt    = sum_wide[SumSqW] ? '1 : sum_wide[SumSqW-1:0];
  assign frames_nxt = (frames_q < FrameW'(MAX_FRAMES)) ? frames_q + 1'b1 : frames_q;

  // Clip counter: arm on a full scale buffer peak, count down on ticks
  assign clip_arm = (held_peak_q >= FullScale && hold_q != '0) ? hold_q : clip_cnt_q;
  assign clip_dec = (clip_cnt_q != '0) ? clip_cnt_q - 1'b1 : clip_cnt_q;

  apm_lvl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_lvl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lvl_start),
    .sum_i    (sum_nxt),
    .frames_i (frames_nxt),
    .done_o   (lvl_done),
    .rms_o    (lvl_rms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      run_peak_q  <= '0;
      sum_sq_q    <= '0;
      frames_q    <= '0;
      held_peak_q <= '0;
      held_rms_q  <= '0;
      clip_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      run_peak_q  <= run_peak_d;
      sum_sq_q    <= sum_sq_d;
      frames_q    <= frames_d;
      held_peak_q <= held_peak_d;
      held_rms_q  <= held_rms_d;
      clip_cnt_q  <= clip_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      last_q <= last_frame_i;
    end
    out_kind_q <= out_kind_d;
    out_peak_q <= out_peak_d;
    out_rms_q  <= out_rms_d;
    out_clip_q <= out_clip_d;
  end

  always_comb begin
    state_d     = state_q;
    start_d     = in_accept && (operation_i == OP_FRAME);
    run_peak_d  = run_peak_q;
    sum_sq_d    = sum_sq_q;
    frames_d    = frames_q;
    held_peak_d = held_peak_q;
    held_rms_d  = held_rms_q;
    clip_cnt_d  = clip_cnt_q;
    lvl_start   = 1'b0;
    // Drop the held result once it is taken
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_peak_d  = out_peak_q;
    out_rms_d   = out_rms_q;
    out_clip_d  = out_clip_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (operation_i == OP_TICK) ? ST_TICK : ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (mrg_valid) begin
          if (last_q) begin
            // Close the buffer: hand the totals to the level unit, clear up
            held_peak_d = peak_nxt;
            lvl_start   = 1'b1;
            run_peak_d  = '0;
            sum_sq_d    = '0;
            frames_d    = '0;
            state_d     = ST_LEVEL;
          end else begin
            run_peak_d = peak_nxt;
            sum_sq_d   = sum_nxt;
            frames_d   = frames_nxt;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_LEVEL: begin
        if (lvl_done) begin
          held_rms_d = lvl_rms;
          state_d    = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          clip_cnt_d  = clip_arm;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_LEVEL;
          out_peak_d  = held_peak_q;
          out_rms_d   = held_rms_q;
          out_clip_d  = (hold_q != '0) && (clip_arm != '0);
          state_d     = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_free) begin
          clip_cnt_d  = clip_dec;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_TICK;
          out_peak_d  = held_peak_q;
          out_rms_d   = held_rms_q;
          out_clip_d  = (hold_q != '0) && (clip_dec != '0);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign peak_level_o       = out_peak_q;
  assign rms_level_o        = out_rms_q;
  assign clipped_recently_o = out_clip_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_FRAME || state_q == ST_TICK))
    else $error("accepted transaction did not start a frame or a tick");

  a_merge_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrg_valid |-> state_q == ST_FRAME)
    else $error("merge result outside of frame processing");

  a_level_done_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_done |-> state_q == ST_LEVEL)
    else $error("level unit finished while not awaited");

  a_frames_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FrameW'(MAX_FRAMES))
    else $error("frame count above its saturation limit");

  a_rms_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_rms_q <= LevelMax)
    else $error("held RMS above full range");

  a_clip_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |-> hold_q != '0)
    else $error("clip indication with hold disabled");
`endif

endmodule
